@@ hw/rtl/rsta_pkg.sv @@
package rsta_pkg;

  localparam int OFFSET_W  = 24;
  localparam int COUNT_W   = 8;
  localparam int WORD_W    = OFFSET_W + COUNT_W;
  localparam int END_W     = OFFSET_W + 1;
  localparam int HDR_W     = 12;
  localparam int COORD_IN_W = 32;

  localparam logic [HDR_W-1:0]  HDR_RESET = 12'd5;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TOO_BIG = 1'b1;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic signed [COORD_IN_W-1:0] chunk_x;
    logic signed [COORD_IN_W-1:0] chunk_z;
    logic [OFFSET_W-1:0]          payload_size;
    logic [WORD_W-1:0]            entry_word;
  } in_word_t;

  typedef struct packed {
    logic                status;
    logic [OFFSET_W-1:0] sector_offset;
    logic [COUNT_W-1:0]  sector_count;
    logic                relocated;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/region_sector_table_allocator_top.sv @@
// Sector allocation table for a REGION_SIDE x REGION_SIDE region, one word per chunk slot.
// REGION_SIDE and SECTOR_BYTES must be powers of two, so the slot is taken from the low bits
// of each coordinate and the sector count from a shift. After reset the table is cleared
// one slot at a time, during which no word is accepted. One input word is then handled
// at a time: a lookup, a load, a failed store or a store that fits its old place passes
// through the READ, DECIDE and FINISH states, its result is registered at the output, and
// the block then returns to idle for the next word. A store that must be appended walks
// the whole table through the memory's single read port to find the highest end sector,
// in added SCAN and SCAN_LAST states before FINISH. A finished result waits in the output
// register while the next word is accepted; a result still held there when the next one
// is ready stalls the block until it is taken.
module region_sector_table_allocator_top #(
  parameter int REGION_SIDE       = 32,
  parameter int SECTOR_BYTES      = 4096,
  parameter int FIRST_DATA_SECTOR = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [rsta_pkg::HDR_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rsta_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rsta_pkg::out_word_t            out_word
);

  localparam int SLOTS    = REGION_SIDE * REGION_SIDE;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int COORD_W  = $clog2(REGION_SIDE);
  localparam int SB_SHIFT = $clog2(SECTOR_BYTES);
  localparam int SUM_W    = rsta_pkg::OFFSET_W + 2;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [rsta_pkg::WORD_W-1:0] word_t;
  typedef logic [rsta_pkg::END_W-1:0]  end_t;
  typedef logic [SUM_W-1:0]   sum_t;

  localparam slot_t  SLOT_LAST = slot_t'(SLOTS - 1);
  localparam end_t   BEST_INIT = end_t'(FIRST_DATA_SECTOR);
  localparam sum_t   ROUND_UP  = sum_t'(SECTOR_BYTES - 1);

  rsta_pkg::state_t state, state_next;

  rsta_pkg::in_word_t item;
  logic [rsta_pkg::HDR_W-1:0] hdr;
  slot_t slot, addr, rd_addr, wr_addr;
  sum_t  bytes_up, need_full;
  logic  need_big;
  logic [rsta_pkg::COUNT_W-1:0] need;
  word_t rd_data, wr_data, res_word, fin_word;
  logic  res_status, res_moved, res_write;
  logic  relocate, mem_we, out_load, out_free, scan_vld;
  end_t  best, scan_end;

  word_t mem [SLOTS];

  assign slot      = {item.chunk_z[COORD_W-1:0], item.chunk_x[COORD_W-1:0]};
  assign bytes_up  = sum_t'(item.payload_size) + sum_t'(hdr) + ROUND_UP;
  assign need_full = bytes_up >> SB_SHIFT;

  assign scan_end = end_t'(rd_data[rsta_pkg::WORD_W-1:rsta_pkg::COUNT_W])
                    + end_t'(rd_data[rsta_pkg::COUNT_W-1:0]);
  assign relocate = (item.opcode == rsta_pkg::OP_STORE) && !need_big
                    && (need > rd_data[rsta_pkg::COUNT_W-1:0]);
  assign fin_word = res_moved ? {best[rsta_pkg::OFFSET_W-1:0], need} : res_word;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      rsta_pkg::ST_CLEAR: begin
        if (addr == SLOT_LAST) state_next = rsta_pkg::ST_IDLE;
      end
      rsta_pkg::ST_IDLE: begin
        if (in_valid) state_next = rsta_pkg::ST_READ;
      end
      rsta_pkg::ST_READ: state_next = rsta_pkg::ST_DECIDE;
      rsta_pkg::ST_DECIDE: begin
        state_next = relocate ? rsta_pkg::ST_SCAN : rsta_pkg::ST_FINISH;
      end
      rsta_pkg::ST_SCAN: begin
        if (addr == SLOT_LAST) state_next = rsta_pkg::ST_SCAN_LAST;
      end
      rsta_pkg::ST_SCAN_LAST: state_next = rsta_pkg::ST_FINISH;
      rsta_pkg::ST_FINISH: begin
        if (out_free) state_next = rsta_pkg::ST_IDLE;
      end
      default: state_next = rsta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    rd_addr  = addr;
    wr_addr  = slot;
    wr_data  = fin_word;
    case (state)
      rsta_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = addr;
        wr_data = '0;
      end
      rsta_pkg::ST_IDLE: in_ready = 1'b1;
      rsta_pkg::ST_READ: rd_addr = slot;
      rsta_pkg::ST_FINISH: begin
        out_load = out_free;
        mem_we   = out_free && res_write;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rsta_pkg::ST_CLEAR;
      hdr       <= rsta_pkg::HDR_RESET;
      out_valid <= 1'b0;
      addr      <= '0;
      scan_vld  <= 1'b0;
    end else begin
      state    <= state_next;
      scan_vld <= (state == rsta_pkg::ST_SCAN);
      if (cfg_wr_en) begin
        hdr <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == rsta_pkg::ST_CLEAR || state == rsta_pkg::ST_SCAN) begin
        addr <= addr + slot_t'(1);
      end else if (state == rsta_pkg::ST_DECIDE) begin
        addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_vld && (scan_end > best)) begin
      best <= scan_end;
    end
    if (out_load) begin
      out_word.status        <= res_status;
      out_word.sector_offset <= fin_word[rsta_pkg::WORD_W-1:rsta_pkg::COUNT_W];
      out_word.sector_count  <= fin_word[rsta_pkg::COUNT_W-1:0];
      out_word.relocated     <= res_moved;
    end
    case (state)
      rsta_pkg::ST_IDLE: begin
        item <= in_word;
      end
      rsta_pkg::ST_READ: begin
        need_big <= |need_full[SUM_W-1:rsta_pkg::COUNT_W];
        need     <= need_full[rsta_pkg::COUNT_W-1:0];
      end
      rsta_pkg::ST_DECIDE: begin
        best <= BEST_INIT;
        case (item.opcode)
          rsta_pkg::OP_LOAD: begin
            res_word   <= item.entry_word;
            res_status <= rsta_pkg::STATUS_OK;
            res_moved  <= 1'b0;
            res_write  <= 1'b1;
          end
          rsta_pkg::OP_STORE: begin
            res_status <= need_big ? rsta_pkg::STATUS_TOO_BIG : rsta_pkg::STATUS_OK;
            res_moved  <= relocate;
            res_write  <= !need_big;
            res_word   <= need_big ? rd_data
                                   : {rd_data[rsta_pkg::WORD_W-1:rsta_pkg::COUNT_W], need};
          end
          default: begin
            res_word   <= rd_data;
            res_status <= rsta_pkg::STATUS_OK;
            res_moved  <= 1'b0;
            res_write  <= 1'b0;
          end
        endcase
      end
      default: begin
        item <= item;
      end
    endcase
  end

endmodule
